// ===== rtl/core/srhs_pkg.sv =====
// Package: shared constants for the sieve row hit solver.
`timescale 1ns / 1ps
package srhs_pkg;
    localparam int unsigned SegResetVal = 35;
    localparam int unsigned CfgBits     = 32;
    localparam int unsigned RowBits     = 32;
endpackage

// ===== rtl/core/srhs_if.sv =====
// Interfaces: valid/ready channels for items, results and configuration.
`timescale 1ns / 1ps
interface srhs_in_if #(parameter int VALUE_BITS = 32);
    logic                  valid;
    logic                  ready;
    logic                  matrix_select;
    logic [VALUE_BITS-1:0] prime_value;
    logic [VALUE_BITS-1:0] column_index;
    modport source(output valid, matrix_select, prime_value, column_index, input ready);
    modport sink(input valid, matrix_select, prime_value, column_index, output ready);
endinterface

interface srhs_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] row_index;
    logic        no_solution;
    modport source(output valid, row_index, no_solution, input ready);
    modport sink(input valid, row_index, no_solution, output ready);
endinterface

interface srhs_cfg_if;
    logic        valid;
    logic        ready;
    logic [31:0] data;
    modport source(output valid, data, input ready);
    modport sink(input valid, data, output ready);
endinterface

// ===== rtl/core/srhs_divider.sv =====
// Bit-serial restoring divider: one quotient bit per cycle.
`timescale 1ns / 1ps
module srhs_divider #(
    parameter int W = 32
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [W-1:0] i_num,
    input  logic [W-1:0] i_den,
    output logic         o_done,
    output logic [W-1:0] o_quo,
    output logic [W-1:0] o_rem
);
    localparam int CW = $clog2(W + 1);
    logic [W-1:0] r_quo, r_rem, r_den;
    logic [CW-1:0] r_cnt;
    logic r_busy, r_done;
    logic [W:0] w_trial;
    logic [W:0] w_sub;

    assign w_trial = {r_rem, r_quo[W-1]};
    assign w_sub   = w_trial - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_quo  <= i_num;
                r_rem  <= '0;
                r_den  <= i_den;
                r_cnt  <= CW'(W);
            end else if (r_busy) begin
                // shift in next numerator bit, try subtract
                if (!w_sub[W]) begin
                    r_rem <= w_sub[W-1:0];
                    r_quo <= {r_quo[W-2:0], 1'b1};
                end else begin
                    r_rem <= w_trial[W-1:0];
                    r_quo <= {r_quo[W-2:0], 1'b0};
                end
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end
    assign o_done = r_done;
    assign o_quo  = r_quo;
    assign o_rem  = r_rem;
endmodule

// ===== rtl/core/srhs_mulmod.sv =====
// Bit-serial modular multiplier: one multiplier bit per cycle, add-and-double.
`timescale 1ns / 1ps
module srhs_mulmod #(
    parameter int W = 32
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [W-1:0] i_a,
    input  logic [W-1:0] i_b,
    input  logic [W-1:0] i_m,
    output logic         o_done,
    output logic [W-1:0] o_prod
);
    logic [W-1:0] r_a, r_b, r_m, r_acc;
    logic r_busy, r_done;
    logic [W:0] w_acc_sum, w_dbl;
    logic [W-1:0] n_acc, n_a;

    assign w_acc_sum = {1'b0, r_acc} + {1'b0, r_a};
    assign w_dbl     = {1'b0, r_a} + {1'b0, r_a};

    always_comb begin
        n_acc = r_acc;
        if (r_b[0]) begin
            n_acc = (w_acc_sum >= {1'b0, r_m}) ? W'(w_acc_sum - {1'b0, r_m})
                                               : w_acc_sum[W-1:0];
        end
        n_a = (w_dbl >= {1'b0, r_m}) ? W'(w_dbl - {1'b0, r_m}) : w_dbl[W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_a    <= i_a;
                r_b    <= i_b;
                r_m    <= i_m;
                r_acc  <= '0;
            end else if (r_busy) begin
                if (r_b == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_acc <= n_acc;
                    r_a   <= n_a;
                    r_b   <= r_b >> 1;
                end
            end
        end
    end
    assign o_done = r_done;
    assign o_prod = r_acc;
endmodule

// ===== rtl/core/sieve_row_hit_solver.sv =====
// Top level: sequencer for gcd, modular inverse and row product.
// Each division step of the extended Euclid loop (at most about 1.5*W steps) is
// followed by one mulmod per step, and a final mulmod forms the row.
// Throughput: one item at a time; an item's run time is set by the shared bit-serial
// divider and modular multiplier.
// Reset: synchronous active-low; segment width returns to 35, sequencer to idle.
`timescale 1ns / 1ps
module sieve_row_hit_solver #(
    parameter int VALUE_BITS = 32
) (
    input  logic i_clk,
    input  logic i_rst_n,
    srhs_in_if.sink    in_ch,
    srhs_out_if.source out_ch,
    srhs_cfg_if.sink   cfg_ch
);
    localparam int W = VALUE_BITS;
    localparam logic [3:0] S_IDLE = 4'd0, S_XP = 4'd1, S_XM = 4'd2, S_VM = 4'd3,
        S_EQ = 4'd4, S_ED = 4'd5, S_EM = 4'd6, S_EU = 4'd7, S_FM = 4'd8,
        S_OUT = 4'd9, S_XPW = 4'd10, S_XMW = 4'd11, S_VMW = 4'd12, S_FMW = 4'd13;

    logic [3:0] r_st;
    logic [31:0] r_seg;
    logic [W-1:0] r_p, r_x, r_vx, r_xp, r_xm, r_r0, r_r1, r_t0, r_t1, r_q;
    logic r_plus;
    logic [31:0] r_row;
    logic r_nosol;

    logic d_start, d_done, m_start, m_done;
    logic [W-1:0] d_num, d_den, d_quo, d_rem, m_a, m_b, m_prod;

    srhs_divider #(.W(W)) u_div (.i_clk, .i_rst_n, .i_start(d_start),
        .i_num(d_num), .i_den(d_den), .o_done(d_done), .o_quo(d_quo), .o_rem(d_rem));
    srhs_mulmod #(.W(W)) u_mul (.i_clk, .i_rst_n, .i_start(m_start),
        .i_a(m_a), .i_b(m_b), .i_m(r_p), .o_done(m_done), .o_prod(m_prod));

    assign cfg_ch.ready = (r_st == S_IDLE);
    assign in_ch.ready  = (r_st == S_IDLE);
    assign out_ch.valid = (r_st == S_OUT);
    assign out_ch.row_index   = r_row;
    assign out_ch.no_solution = r_nosol;

    logic [W-1:0] w_sub_t;  // (t0 - prod) mod p
    assign w_sub_t = (r_t0 >= m_prod) ? r_t0 - m_prod : r_p - (m_prod - r_t0);

    logic [W-1:0] w_xp_base;  // (p+1)/6 from p/6 and p%6
    assign w_xp_base = d_quo + ((d_rem == W'(5)) ? W'(1) : W'(0));

    always_comb begin
        d_start = 1'b0; d_num = r_p; d_den = W'(6);
        m_start = 1'b0; m_a = r_q; m_b = r_t1;
        case (r_st)
            S_XP: begin d_start = 1'b1; end
            S_XM: begin d_start = 1'b1; d_num = r_x; d_den = r_p; end
            S_VM: begin d_start = 1'b1; d_num = r_vx; d_den = r_p; end
            S_EQ: begin d_start = 1'b1; d_num = r_r0; d_den = r_r1; end
            S_EM: begin m_start = 1'b1; end
            S_FM: begin
                m_start = 1'b1;
                m_a = (r_xp >= r_xm) ? r_xp - r_xm : r_p - (r_xm - r_xp);
                m_b = r_t0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st  <= S_IDLE;
            r_seg <= srhs_pkg::SegResetVal;
        end else begin
            case (r_st)
                S_IDLE: begin
                    if (cfg_ch.valid) r_seg <= cfg_ch.data;
                    if (in_ch.valid) begin
                        r_plus <= in_ch.matrix_select;
                        r_p    <= in_ch.prime_value;
                        r_x    <= in_ch.column_index;
                        r_vx   <= W'(r_seg);
                        r_st   <= S_XP;
                    end
                end
                S_XP: r_st <= S_XPW;
                S_XPW: if (d_done) begin
                    // xp = (p+1)/6, flipped when class differs from matrix
                    r_xp <= (((d_rem == W'(1)) != r_plus) ? r_p - w_xp_base : w_xp_base);
                    if (r_p == '0) begin
                        r_row <= '0; r_nosol <= 1'b1; r_st <= S_OUT;
                    end else r_st <= S_XM;
                end
                S_XM: r_st <= S_XMW;
                S_XMW: if (d_done) begin r_xm <= d_rem; r_st <= S_VM; end
                S_VM: r_st <= S_VMW;
                S_VMW: if (d_done) begin
                    // Euclid on (p, vx mod p); gcd(vx,p) == gcd(p, vx mod p)
                    r_r0 <= r_p; r_r1 <= d_rem; r_t0 <= '0; r_t1 <= W'(1);
                    r_st <= S_ED;
                end
                S_ED: begin
                    if (r_r1 == '0) begin
                        if (r_r0 != W'(1)) begin
                            r_row <= '0; r_nosol <= 1'b1; r_st <= S_OUT;
                        end else if (r_xm == r_xp || r_p == W'(1)) begin
                            r_row <= '0; r_nosol <= 1'b0; r_st <= S_OUT;
                        end else r_st <= S_FM;
                    end else r_st <= S_EQ;
                end
                S_EQ: r_st <= S_EU;
                S_EU: begin
                    // wait quotient, then q mod p (q <= p since r1 >= 1, r0 <= p)
                    if (d_done) begin
                        r_q  <= (d_quo >= r_p) ? d_quo - r_p : d_quo;
                        r_r0 <= r_r1; r_r1 <= d_rem;
                        r_st <= S_EM;
                    end else if (m_done) begin
                        r_t0 <= r_t1; r_t1 <= w_sub_t; r_st <= S_ED;
                    end
                end
                S_EM: r_st <= S_EU;
                S_FM: r_st <= S_FMW;
                S_FMW: if (m_done) begin
                    r_row <= 32'(m_prod); r_nosol <= 1'b0; r_st <= S_OUT;
                end
                S_OUT: if (out_ch.ready) r_st <= S_IDLE;
                default: r_st <= S_IDLE;
            endcase
        end
    end
endmodule

// ===== rtl/core/srhs_checker.sv =====
// Checker: port-level properties of the solver, bound to the top level.
`timescale 1ns / 1ps
module srhs_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] out_row,
    input logic        out_nosol
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_row))
        else $error("result dropped");
    a_nosol_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && out_nosol |-> out_row == '0)
        else $error("no-solution row not zero");
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second item taken while busy");
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(out_valid && in_ready))
        else $error("input open while result pending");
endmodule

bind sieve_row_hit_solver srhs_checker u_chk (
    .i_clk, .i_rst_n,
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .out_row(out_ch.row_index), .out_nosol(out_ch.no_solution)
);
